FILE: rtl/core/tridiagonal_thomas_solver_defines.svh
// ---------------------------------------------------------------------------
// Tridiagonal solver assertion macros
// Shared assertion wrappers for the solver RTL.
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH

// check a property on the rising edge of clk, off while reset is held
`define TTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define TTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tts_pkg.sv
// ---------------------------------------------------------------------------
// Tridiagonal solver package
// Transaction types, sequencer states and fixed-point helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam int Q_W           = 32;
	localparam int IDX_W         = 6;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic signed [Q_W-1:0] sub_diag;
		logic signed [Q_W-1:0] main_diag;
		logic signed [Q_W-1:0] super_diag;
		logic signed [Q_W-1:0] rhs;
		logic                  last_row;
	} row_t;

	typedef struct packed {
		logic signed [Q_W-1:0] solution;
		logic [IDX_W-1:0]      row_index;
		logic                  fault;
		logic                  last_result;
	} res_t;

	typedef struct packed {
		logic signed [Q_W-1:0] val;
		logic                  flt;
	} sat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULS,
		S_MULR,
		S_FIN,
		S_DIV,
		S_DWAIT,
		S_BRD,
		S_BMUL,
		S_BSUB,
		S_EMIT
	} state_t;

	// shift a full product down by the fraction bits (floor), then saturate
	function automatic sat_t q_mul_fin(input logic signed [2*Q_W-1:0] p, input int frac);
		logic signed [2*Q_W-1:0] sh;
		sat_t r;
		sh = p >>> frac;
		if (sh > 64'sh0000_0000_7fff_ffff) begin
			r.val = 32'sh7fff_ffff;
			r.flt = 1'b1;
		end else if (sh < -64'sh0000_0000_8000_0000) begin
			r.val = 32'sh8000_0000;
			r.flt = 1'b1;
		end else begin
			r.val = sh[Q_W-1:0];
			r.flt = 1'b0;
		end
		return r;
	endfunction

	// exact difference, saturated to the word
	function automatic sat_t q_sub(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] d;
		sat_t r;
		d = {a[Q_W-1], a} - {b[Q_W-1], b};
		if (d[Q_W] != d[Q_W-1]) begin
			r.val = d[Q_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			r.flt = 1'b1;
		end else begin
			r.val = d[Q_W-1:0];
			r.flt = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tts_div.sv
// ---------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle, (num << FRAC_BITS) / den,
// truncated toward zero and saturated; zero denominator flagged.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tridiagonal_thomas_solver_defines.svh"

module tts_div #(
	parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic signed [tts_pkg::Q_W-1:0] num,
	input  wire logic signed [tts_pkg::Q_W-1:0] den,
	output      logic                           done,
	output      tts_pkg::sat_t                  quot
);
	import tts_pkg::*;

	localparam int NW = Q_W + FRAC_BITS;
	localparam int QB = Q_W + 1;

	logic [NW-1:0]   n_full;
	logic [Q_W-1:0]  num_mag;
	logic [Q_W-1:0]  den_mag;
	logic            busy_q;
	logic            fin_q;
	logic            done_q;
	logic [5:0]      cnt_q;
	logic [Q_W-1:0]  dm_q;
	logic [Q_W-1:0]  rem_q;
	logic [QB-1:0]   lo_q;
	logic [QB-1:0]   q_q;
	logic            neg_q;
	logic            ovf_q;
	logic            zero_q;
	logic            npos_q;
	logic [Q_W:0]    trial;
	logic            take;
	sat_t            res_d;
	sat_t            quot_q;
	logic [QB-1:0]   qneg;

	assign num_mag = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
	assign den_mag = den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
	assign n_full  = {num_mag, FRAC_BITS'(0)};
	assign trial   = {rem_q, lo_q[QB-1]};
	assign take    = trial >= {1'b0, dm_q};
	assign qneg    = QB'(-q_q);

	always_comb begin
		if (zero_q) begin
			res_d.val = npos_q ? 32'sh7fff_ffff : 32'sh8000_0000;
			res_d.flt = 1'b1;
		end else if (ovf_q || (!neg_q && q_q[QB-1:Q_W-1] != 2'b00)) begin
			res_d.val = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
			res_d.flt = 1'b1;
		end else if (neg_q && q_q > QB'(33'h0_8000_0000)) begin
			res_d.val = 32'sh8000_0000;
			res_d.flt = 1'b1;
		end else begin
			res_d.val = neg_q ? qneg[Q_W-1:0] : q_q[Q_W-1:0];
			res_d.flt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QB - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dm_q   <= den_mag;
			rem_q  <= Q_W'(n_full[NW-1:QB]);
			lo_q   <= n_full[QB-1:0];
			q_q    <= '0;
			neg_q  <= num[Q_W-1] ^ den[Q_W-1];
			ovf_q  <= Q_W'(n_full[NW-1:QB]) >= den_mag;
			zero_q <= den == '0;
			npos_q <= !num[Q_W-1];
		end else if (busy_q) begin
			rem_q <= take ? Q_W'(trial - {1'b0, dm_q}) : trial[Q_W-1:0];
			lo_q  <= {lo_q[QB-2:0], 1'b0};
			q_q   <= {q_q[QB-2:0], take};
		end
		if (fin_q) begin
			quot_q <= res_d;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	`TTS_ASSERT(a_start_busy, start |=> busy_q, "divider did not start")
	`TTS_ASSERT(a_no_overlap, start |-> !busy_q && !fin_q, "divider restarted while working")
	`TTS_ASSERT(a_done_after_fin, done |-> $past(fin_q), "divider result out of sequence")

endmodule

`default_nettype wire

FILE: rtl/core/tridiagonal_thomas_solver.sv
// ---------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm in signed fixed point: forward sweep per row into c'/d'
// memories, then back substitution and emission of one solution per cycle.
// ---------------------------------------------------------------------------
// Each row holds busy through its forward step and the two parallel 33-step dividers;
// row 0 skips the multiply steps. The final row then runs back substitution over
// each earlier row, and the results stream out one per cycle, highest row first.
// A new row is taken only once busy drops, so the bit-serial dividers set the row rate.
// Reset clears row count, fault and sequencer; memories are not cleared.
// Results cannot be stalled; busy stays high until the last one is issued.
`default_nettype none
`include "tridiagonal_thomas_solver_defines.svh"

module tridiagonal_thomas_solver #(
	parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
	parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire tts_pkg::row_t row,
	output      logic          result_valid,
	output      tts_pkg::res_t result
);
	import tts_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);

	state_t state_q, state_d;

	// c' and d' stores, one write and one registered read each
	logic signed [Q_W-1:0] sup_mem [MAX_ROWS];
	logic signed [Q_W-1:0] rhs_mem [MAX_ROWS];
	logic signed [Q_W-1:0] sup_rd;
	logic signed [Q_W-1:0] rhs_rd;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_sup;
	logic                  wr_rhs;
	logic [AW-1:0]         wr_addr;
	logic signed [Q_W-1:0] wr_sup_data;
	logic signed [Q_W-1:0] wr_rhs_data;
	logic                  div_start;

	logic [CW-1:0]         rows_q;
	logic                  fault_q;
	logic [AW-1:0]         cur_i;
	logic                  cur_last;

	logic signed [Q_W-1:0] a_q, b_q, c_q, d_q;
	logic                  last_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         k_q;
	logic signed [Q_W-1:0] den_q, num_q, x_q;
	logic signed [2*Q_W-1:0] prod_q;

	logic                  div0_done, div1_done;
	sat_t                  div0_q, div1_q;
	sat_t                  mul_r, den_r, num_r, x_r;

	logic                  rv_s1;
	logic [AW-1:0]         idx_s1;
	logic                  flt_s1;
	logic                  last_s1;

	// row slot for an incoming transaction, and whether it closes the system
	assign cur_i    = (rows_q >= CW'(MAX_ROWS)) ? '0 : rows_q[AW-1:0];
	assign cur_last = row.last_row || (({1'b0, cur_i} + CW'(1)) >= CW'(MAX_ROWS));

	assign mul_r = q_mul_fin(prod_q, FRAC_BITS);
	assign den_r = q_sub(b_q, mul_r.val);
	assign num_r = q_sub(d_q, mul_r.val);
	assign x_r   = q_sub(rhs_rd, mul_r.val);

	// one divider for c'/den, one for d'/den, run side by side
	tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_sup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (c_q),
		.den    (den_q),
		.done   (div0_done),
		.quot   (div0_q)
	);

	tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div1_done),
		.quot   (div1_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cur_i == '0) ? S_DIV : S_MULS;
				end
			end
			S_MULS:  state_d = S_MULR;
			S_MULR:  state_d = S_FIN;
			S_FIN:   state_d = S_DIV;
			S_DIV:   state_d = S_DWAIT;
			S_DWAIT: begin
				if (div0_done) begin
					if (!last_q) begin
						state_d = S_IDLE;
					end else if (idx_q == '0) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_BRD;
					end
				end
			end
			S_BRD:   state_d = S_BMUL;
			S_BMUL:  state_d = S_BSUB;
			S_BSUB:  state_d = (k_q == AW'(1)) ? S_EMIT : S_BRD;
			S_EMIT:  state_d = (k_q == '0) ? S_IDLE : S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_sup      = 1'b0;
		wr_rhs      = 1'b0;
		wr_addr     = idx_q;
		wr_sup_data = div0_q.val;
		wr_rhs_data = div1_q.val;
		div_start   = 1'b0;
		busy        = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = start && cur_i != '0;
				rd_addr = cur_i - AW'(1);
			end
			S_DIV: begin
				div_start = 1'b1;
			end
			S_DWAIT: begin
				wr_sup = div0_done;
				wr_rhs = div0_done;
			end
			S_BRD: begin
				rd_en   = 1'b1;
				rd_addr = k_q - AW'(1);
			end
			S_BSUB: begin
				wr_rhs      = 1'b1;
				wr_addr     = k_q - AW'(1);
				wr_rhs_data = x_r.val;
			end
			S_EMIT: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_sup) begin
			sup_mem[wr_addr] <= wr_sup_data;
		end
		if (wr_rhs) begin
			rhs_mem[wr_addr] <= wr_rhs_data;
		end
		if (rd_en) begin
			sup_rd <= sup_mem[rd_addr];
			rhs_rd <= rhs_mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q  <= '0;
			fault_q <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= state_q == S_EMIT;
			unique case (state_q)
				S_MULR: fault_q <= fault_q | mul_r.flt | den_r.flt;
				S_FIN:  fault_q <= fault_q | mul_r.flt | num_r.flt;
				S_DWAIT: begin
					if (div0_done) begin
						fault_q <= fault_q | div0_q.flt | div1_q.flt;
						rows_q  <= CW'(idx_q) + CW'(1);
					end
				end
				S_BSUB: fault_q <= fault_q | mul_r.flt | x_r.flt;
				S_EMIT: begin
					// drop the system once row 0 is issued
					if (k_q == '0) begin
						rows_q  <= '0;
						fault_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					a_q    <= row.sub_diag;
					b_q    <= row.main_diag;
					c_q    <= cur_last ? '0 : row.super_diag;
					d_q    <= row.rhs;
					last_q <= cur_last;
					idx_q  <= cur_i;
					den_q  <= row.main_diag;
					num_q  <= row.rhs;
				end
			end
			S_MULS: prod_q <= a_q * sup_rd;
			S_MULR: begin
				den_q  <= den_r.val;
				prod_q <= a_q * rhs_rd;
			end
			S_FIN:  num_q <= num_r.val;
			S_DWAIT: begin
				x_q <= div1_q.val;
				k_q <= idx_q;
			end
			S_BMUL: prod_q <= sup_rd * x_q;
			S_BSUB: begin
				x_q <= x_r.val;
				k_q <= (k_q == AW'(1)) ? idx_q : k_q - AW'(1);
			end
			S_EMIT: begin
				idx_s1  <= k_q;
				last_s1 <= k_q == '0;
				flt_s1  <= fault_q;
				k_q     <= k_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	assign result_valid       = rv_s1;
	assign result.solution    = rhs_rd;
	assign result.row_index   = IDX_W'(idx_s1);
	assign result.fault       = flt_s1;
	assign result.last_result = last_s1;

	`TTS_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted row left the block idle")
	`TTS_ASSERT(a_result_busy, result_valid && !result.last_result |-> busy,
		"results ran out before row 0")
	`TTS_ASSERT(a_run_end, result_valid && result.last_result |=> !result_valid,
		"result issued after row 0")
	`TTS_ASSERT_ALWAYS(a_rows_range, !arst_n || rows_q <= CW'(MAX_ROWS),
		"row count beyond limit")

endmodule

`default_nettype wire

FILE: sim/tb_tridiagonal_thomas_solver.sv
// ---------------------------------------------------------------------------
// Tridiagonal solver testbench
// Feeds row transactions of tridiagonal systems through the command port,
// predicts every solution with a local fixed-point Thomas sweep and checks
// each emitted result in order against the predicted queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_tridiagonal_thomas_solver;
	import tts_pkg::*;

	localparam int ROWS_CAP  = MAX_ROWS_DEF;
	localparam int FRAC      = FRAC_BITS_DEF;
	localparam longint Q_HI  = 64'sd2147483647;
	localparam longint Q_LO  = -64'sd2147483648;
	localparam longint CYCLE_LIMIT = 2000000;

	// scoreboard: holds the forward-sweep state and the solutions still owed
	class solution_board;
		longint cp[ROWS_CAP];
		longint dp[ROWS_CAP];
		int     rows_in;
		bit     flt;
		res_t   owed[$];
		int     errors;

		function new();
			rows_in = 0;
			flt = 0;
			errors = 0;
		endfunction

		function longint clamp(longint v);
			if (v > Q_HI) begin
				flt = 1;
				return Q_HI;
			end
			if (v < Q_LO) begin
				flt = 1;
				return Q_LO;
			end
			return v;
		endfunction

		// floor shift of the exact product
		function longint fx_mul(longint a, longint b);
			longint p;
			p = a * b;
			return clamp(p >>> FRAC);
		endfunction

		function longint fx_div(longint num, longint den);
			if (den == 0) begin
				flt = 1;
				return (num >= 0) ? Q_HI : Q_LO;
			end
			// SV integer division truncates toward zero
			return clamp((num * (64'sd1 <<< FRAC)) / den);
		endfunction

		// advance the sweep by one row; queue the solutions when the system closes
		function void note_row(row_t r);
			longint a, b, c, d, den, num;
			longint x[ROWS_CAP];
			res_t e;
			int i, n;
			bit fin;
			a = longint'(r.sub_diag);
			b = longint'(r.main_diag);
			c = longint'(r.super_diag);
			d = longint'(r.rhs);
			fin = r.last_row;
			i = (rows_in >= ROWS_CAP) ? 0 : rows_in;
			if (i + 1 >= ROWS_CAP) fin = 1;
			if (fin) c = 0;
			if (i == 0) begin
				den = b;
				num = d;
			end else begin
				den = clamp(b - fx_mul(a, cp[i-1]));
				num = clamp(d - fx_mul(a, dp[i-1]));
			end
			cp[i] = fx_div(c, den);
			dp[i] = fx_div(num, den);
			rows_in = i + 1;
			if (!fin) return;
			n = i + 1;
			x[n-1] = dp[n-1];
			for (int k = n - 1; k > 0; k--)
				x[k-1] = clamp(dp[k-1] - fx_mul(cp[k-1], x[k]));
			for (int k = n; k > 0; k--) begin
				e.solution    = x[k-1][31:0];
				e.row_index   = 6'(k - 1);
				e.fault       = flt;
				e.last_result = (k == 1);
				owed.push_back(e);
			end
			rows_in = 0;
			flt = 0;
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (owed.size() == 0) begin
				$error("unexpected result row_index=%0d", got.row_index);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.solution !== e.solution) begin
				$error("solution: expected %0d, got %0d", e.solution, got.solution);
				errors++;
			end
			if (got.row_index !== e.row_index) begin
				$error("row_index: expected %0d, got %0d", e.row_index, got.row_index);
				errors++;
			end
			if (got.fault !== e.fault) begin
				$error("fault: expected %0b, got %0b", e.fault, got.fault);
				errors++;
			end
			if (got.last_result !== e.last_result) begin
				$error("last_result: expected %0b, got %0b", e.last_result,
					got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic  clk = 0;
	logic  arst_n = 0;
	logic  start = 0;
	row_t  row = '0;
	logic  busy;
	logic  result_valid;
	res_t  result;
	longint cycles = 0;
	bit    gaps_on = 1;
	solution_board board;

	tridiagonal_thomas_solver DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.row(row), .result_valid(result_valid), .result(result)
	);

	always #6 clk = ~clk;

	// check every result strobe; the receiver never stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid) board.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// random Q16.16 value: mostly moderate, sometimes a full 32-bit word
	function automatic logic [31:0] pick_q();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'h0;
			default: return 32'($signed($urandom_range(0, 32'h0008_0000))
				- 32'sh0004_0000);
		endcase
	endfunction

	// diagonally dominant row so the sweep stays well conditioned
	function automatic row_t tame_row(bit fin);
		row_t r;
		r.sub_diag   = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
		r.super_diag = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
		r.main_diag  = 32'h0004_0000 + $urandom_range(0, 32'h0004_0000);
		if ($urandom_range(0, 1)) r.main_diag = -r.main_diag;
		r.rhs        = pick_q();
		r.last_row   = fin;
		return r;
	endfunction

	// hand one row transaction to the block and note it on acceptance
	task automatic send_row(row_t r);
		// advance one edge so start is never driven twice in one time step
		@(posedge clk);
		if (gaps_on)
			while ($urandom_range(0, 99) < 35) @(posedge clk);
		start <= 1'b1;
		row   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_row(r);
		start <= 1'b0;
	endtask

	task automatic send_system(int n, bit wild);
		row_t r;
		for (int k = 0; k < n; k++) begin
			if (wild) begin
				r.sub_diag = pick_q(); r.main_diag = pick_q();
				r.super_diag = pick_q(); r.rhs = pick_q();
				r.last_row = (k == n - 1);
			end else r = tame_row(k == n - 1);
			send_row(r);
		end
	endtask

	initial begin
		row_t r;
		int sent;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-row system, then a zero pivot on row 0
		r = '{sub_diag: 32'h7fff_ffff, main_diag: 32'h0002_0000, super_diag: 32'h8000_0000,
			rhs: 32'h0003_0000, last_row: 1'b1};
		send_row(r);
		r = '{sub_diag: 32'h0, main_diag: 32'h0, super_diag: 32'h0001_0000,
			rhs: 32'h8000_0000, last_row: 1'b0};
		send_row(r);
		r = '{sub_diag: 32'h8000_0000, main_diag: 32'h7fff_ffff, super_diag: 32'hffff_ffff,
			rhs: 32'h7fff_ffff, last_row: 1'b1};
		send_row(r);
		// zero pivot with positive numerator, then saturating extremes
		r = '{sub_diag: 32'h0, main_diag: 32'h0, super_diag: 32'h0,
			rhs: 32'h0001_0000, last_row: 1'b1};
		send_row(r);
		send_system(4, 1);
		send_system(3, 0);
		// hold off until the block has drained every owed solution
		while (board.owed.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		send_system(5, 0);
		sent = 16;

		// row limit: a full system that never marks its last row
		gaps_on = 0;
		for (int k = 0; k < ROWS_CAP; k++) begin
			r = tame_row(1'b0);
			send_row(r);
		end
		gaps_on = 1;
		sent += ROWS_CAP;

		while (sent < 150) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
			send_system(n, $urandom_range(0, 4) == 0);
			sent += n;
		end

		while (board.owed.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire
